// ===== rtl/positional_array_list_engine_top_macros.svh =====
// Assertion macros used by the checker file of the list engine.
`ifndef POSITIONAL_ARRAY_LIST_ENGINE_TOP_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_ENGINE_TOP_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define PALE_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define PALE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`endif

// ===== rtl/pale_pkg.sv =====
package pale_pkg;

  // List geometry
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // Field widths of the channels
  localparam int COMMAND_W  = 2;
  localparam int VALUE_W    = 32;
  localparam int POSITION_W = 5;
  localparam int STATUS_W   = 3;
  localparam int ENTRY_W    = 5;

  // Internal widths
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

  // Command codes
  localparam logic [COMMAND_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [COMMAND_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [COMMAND_W-1:0] CMD_READ   = 2'd2;
  localparam logic [COMMAND_W-1:0] CMD_CLEAR  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [COMMAND_W-1:0]      command;
    logic signed [VALUE_W-1:0] value;
    logic [POSITION_W-1:0]     position;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] read_value;
    logic [ENTRY_W-1:0]        entry_count;
    logic                      is_empty;
  } res_t;

endpackage

// ===== rtl/pale_cmd_if.sv =====
interface pale_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [pale_pkg::COMMAND_W-1:0]      command;
  logic signed [pale_pkg::VALUE_W-1:0] value;
  logic [pale_pkg::POSITION_W-1:0]     position;

  modport source (output valid, command, value, position, input ready);
  modport sink (input valid, command, value, position, output ready);
endinterface

// ===== rtl/pale_rsp_if.sv =====
interface pale_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [pale_pkg::STATUS_W-1:0]       status;
  logic signed [pale_pkg::VALUE_W-1:0] read_value;
  logic [pale_pkg::ENTRY_W-1:0]        entry_count;
  logic                                is_empty;

  modport source (output valid, status, read_value, entry_count, is_empty, input ready);
  modport sink (input valid, status, read_value, entry_count, is_empty, output ready);
endinterface

// ===== rtl/pale_seq.sv =====
// Sequencer that walks the entry memory, one command at a time.
module pale_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  pale_pkg::req_t  req,
  output logic            res_valid,
  input  logic            res_take,
  output pale_pkg::res_t  res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_DN   = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]                          state, state_next;
  logic [pale_pkg::CNT_W-1:0]          count, count_next;
  logic [pale_pkg::CNT_W-1:0]          idx, idx_next;
  logic                                rd_pend, rd_pend_next;
  logic [pale_pkg::IDX_W-1:0]          rd_pend_idx, rd_pend_idx_next;
  logic [pale_pkg::DATA_WIDTH-1:0]     val_r;
  logic [pale_pkg::POSITION_W-1:0]     pos_r;
  logic [pale_pkg::STATUS_W-1:0]       status, status_next;
  logic signed [pale_pkg::VALUE_W-1:0] rdval, rdval_next;

  // Memory port signals
  logic [pale_pkg::DATA_WIDTH-1:0] mem [pale_pkg::CAPACITY];
  logic                            rd_en, wr_en;
  logic [pale_pkg::IDX_W-1:0]      rd_addr, wr_addr;
  logic [pale_pkg::DATA_WIDTH-1:0] rd_data, wr_data;

  logic                       accept;
  logic [pale_pkg::CMP_W-1:0] pos_in_w, pos_r_w, cnt_w, idx_w;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);
  assign pos_in_w  = pale_pkg::CMP_W'(req.position);
  assign pos_r_w   = pale_pkg::CMP_W'(pos_r);
  assign cnt_w     = pale_pkg::CMP_W'(count);
  assign idx_w     = pale_pkg::CMP_W'(idx);

  // Result as seen after the command
  assign res.status      = status;
  assign res.read_value  = rdval;
  assign res.entry_count = pale_pkg::ENTRY_W'(count);
  assign res.is_empty    = (count == '0);

  // Entry storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Sequencer
  always_comb begin
    state_next       = state;
    count_next       = count;
    idx_next         = idx;
    rd_pend_next     = 1'b0;
    rd_pend_idx_next = rd_pend_idx;
    status_next      = status;
    rdval_next       = rdval;
    rd_en            = 1'b0;
    rd_addr          = '0;
    wr_en            = 1'b0;
    wr_addr          = '0;
    wr_data          = rd_data;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          status_next = pale_pkg::ST_OK;
          rdval_next  = '0;
          unique case (req.command)
            pale_pkg::CMD_INSERT: begin
              if (pos_in_w > cnt_w) begin
                status_next = pale_pkg::ST_RANGE;
                state_next  = S_EMIT;
              end else if (count == pale_pkg::CNT_W'(pale_pkg::CAPACITY)) begin
                status_next = pale_pkg::ST_FULL;
                state_next  = S_EMIT;
              end else begin
                idx_next   = count;
                state_next = S_UP;
              end
            end
            pale_pkg::CMD_REMOVE: begin
              if (count == '0) begin
                status_next = pale_pkg::ST_EMPTY;
                state_next  = S_EMIT;
              end else begin
                idx_next   = '0;
                state_next = S_SRCH;
              end
            end
            pale_pkg::CMD_READ: begin
              if (count == '0) begin
                status_next = pale_pkg::ST_EMPTY;
                state_next  = S_EMIT;
              end else if (pos_in_w >= cnt_w) begin
                status_next = pale_pkg::ST_RANGE;
                state_next  = S_EMIT;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = pale_pkg::IDX_W'(req.position);
                state_next = S_RD;
              end
            end
            default: begin
              count_next = '0;
              state_next = S_EMIT;
            end
          endcase
        end
      end

      // Shift entries up from the tail, then drop the new value in
      S_UP: begin
        if (rd_pend) begin
          wr_en   = 1'b1;
          wr_addr = rd_pend_idx + pale_pkg::IDX_W'(1);
          wr_data = rd_data;
        end
        if (idx_w > pos_r_w) begin
          rd_en            = 1'b1;
          rd_addr          = pale_pkg::IDX_W'(idx - pale_pkg::CNT_W'(1));
          rd_pend_next     = 1'b1;
          rd_pend_idx_next = pale_pkg::IDX_W'(idx - pale_pkg::CNT_W'(1));
          idx_next         = idx - pale_pkg::CNT_W'(1);
        end else if (!rd_pend) begin
          wr_en      = 1'b1;
          wr_addr    = pale_pkg::IDX_W'(pos_r);
          wr_data    = val_r;
          count_next = count + pale_pkg::CNT_W'(1);
          state_next = S_EMIT;
        end
      end

      // Linear search, one read issued and one compare per cycle
      S_SRCH: begin
        if (rd_pend && (rd_data == val_r)) begin
          idx_next   = pale_pkg::CNT_W'(rd_pend_idx) + pale_pkg::CNT_W'(1);
          state_next = S_DN;
        end else if (rd_pend &&
                     (pale_pkg::CNT_W'(rd_pend_idx) == count - pale_pkg::CNT_W'(1))) begin
          status_next = pale_pkg::ST_NOT_FOUND;
          state_next  = S_EMIT;
        end else begin
          rd_en            = 1'b1;
          rd_addr          = pale_pkg::IDX_W'(idx);
          rd_pend_next     = 1'b1;
          rd_pend_idx_next = pale_pkg::IDX_W'(idx);
          idx_next         = idx + pale_pkg::CNT_W'(1);
        end
      end

      // Close the gap: move each later entry down by one
      S_DN: begin
        if (rd_pend) begin
          wr_en   = 1'b1;
          wr_addr = rd_pend_idx - pale_pkg::IDX_W'(1);
          wr_data = rd_data;
        end
        if (idx < count) begin
          rd_en            = 1'b1;
          rd_addr          = pale_pkg::IDX_W'(idx);
          rd_pend_next     = 1'b1;
          rd_pend_idx_next = pale_pkg::IDX_W'(idx);
          idx_next         = idx + pale_pkg::CNT_W'(1);
        end else if (!rd_pend) begin
          count_next = count - pale_pkg::CNT_W'(1);
          state_next = S_EMIT;
        end
      end

      S_RD: begin
        rdval_next = pale_pkg::VALUE_W'($signed(rd_data));
        state_next = S_EMIT;
      end

      S_EMIT: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rd_pend <= rd_pend_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    idx         <= idx_next;
    rd_pend_idx <= rd_pend_idx_next;
    status      <= status_next;
    rdval       <= rdval_next;
    if (accept) begin
      val_r <= pale_pkg::DATA_WIDTH'($signed(req.value));
      pos_r <= req.position;
    end
  end

endmodule

// ===== rtl/positional_array_list_engine_top.sv =====
// Clear and rejected commands go straight to the response; read fetches one entry; insert
// shifts the entries from the tail down to the position up by one (none at position count)
// before writing; remove searches linearly and, when the value is found, closes the gap. One
// command at a time: the next can be taken in the cycle after the result enters the output
// register, since the sequencer waits in its emit state until the output register takes it.
// Reset (rst, synchronous) empties the list and drops any pending response; no clearing pass.
module positional_array_list_engine_top (
  input  logic       clk,
  input  logic       rst,
  pale_cmd_if.sink   cmd,
  pale_rsp_if.source rsp
);

  pale_pkg::req_t req;
  pale_pkg::res_t res;
  pale_pkg::res_t out_r;
  logic           res_valid;
  logic           res_take;
  logic           out_valid;

  assign req.command  = cmd.command;
  assign req.value    = cmd.value;
  assign req.position = cmd.position;

  pale_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (cmd.valid),
    .req_ready (cmd.ready),
    .req       (req),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Output register: loads when empty or being drained
  assign res_take = res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_r.status;
  assign rsp.read_value  = out_r.read_value;
  assign rsp.entry_count = out_r.entry_count;
  assign rsp.is_empty    = out_r.is_empty;

endmodule

// ===== rtl/pale_chk.sv =====
`include "positional_array_list_engine_top_macros.svh"

// Port-level checks on the response channel.
module pale_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic [pale_pkg::STATUS_W-1:0]       rsp_status,
  input logic signed [pale_pkg::VALUE_W-1:0] rsp_read_value,
  input logic [pale_pkg::ENTRY_W-1:0]        rsp_entry_count,
  input logic                                rsp_is_empty
);

  // A stalled response stays valid with its status and entry count held
  `PALE_ASSERT_NEXT(a_rsp_hold, clk, rst, (rsp_valid && !rsp_ready), (rsp_valid && $stable(rsp_status) && $stable(rsp_entry_count)), "response dropped or changed while stalled")

  // Count never exceeds the capacity
  `PALE_ASSERT(a_count_cap, clk, rst, (rsp_valid |-> (rsp_entry_count <= pale_pkg::ENTRY_W'(pale_pkg::CAPACITY))), "entry count above capacity")

  // Empty flag agrees with the count
  `PALE_ASSERT(a_empty_flag, clk, rst, (rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0))), "empty flag disagrees with entry count")

  // Only a good status carries read data
  `PALE_ASSERT(a_rdval_zero, clk, rst, ((rsp_valid && (rsp_status != pale_pkg::ST_OK)) |-> (rsp_read_value == '0)), "read value nonzero on failed command")

endmodule

bind positional_array_list_engine_top pale_chk u_pale_chk (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_read_value  (rsp.read_value),
  .rsp_entry_count (rsp.entry_count),
  .rsp_is_empty    (rsp.is_empty)
);
